>>> sv/quaternion_to_euler_angles_top_defines.svh
// Assertion macros shared by the checker of the quaternion to Euler angles block.
// Depends on a clk and a rst signal in the scope where a macro is used.
`ifndef QUATERNION_TO_EULER_ANGLES_TOP_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define QTE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define QTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/qte_pkg.sv
// Types, constants and tables for the quaternion to Euler angles block.
// No dependencies.
package qte_pkg;

  localparam int QUAT_BITS = 16;
  localparam int SHW       = $clog2(QUAT_BITS) + 1;  // normalizing shift amount
  localparam int MW        = 35;                     // matrix entries, signed
  localparam int RB        = 32;                     // square root result bits
  localparam int CW        = 38;                     // CORDIC x/y, signed
  localparam int ZW        = 26;                     // angle, degrees * 65536
  localparam int TAB_LEN   = 24;
  localparam int DEG_ONE   = 65536;
  localparam int OUT_LIMIT = 23040;
  localparam int GIMBAL_DEN = 10000000;

  localparam logic signed [ZW-1:0] Z90 = ZW'(90 * DEG_ONE);

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_GIMBAL  = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_ZERO    = 2'd3;

  localparam logic [2:0] ORD_XYZ = 3'd0;
  localparam logic [2:0] ORD_XZY = 3'd1;
  localparam logic [2:0] ORD_YXZ = 3'd2;
  localparam logic [2:0] ORD_YZX = 3'd3;
  localparam logic [2:0] ORD_ZXY = 3'd4;
  localparam logic [2:0] ORD_ZYX = 3'd5;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  typedef struct packed {
    logic signed [QUAT_BITS-1:0] quat_w;
    logic signed [QUAT_BITS-1:0] quat_x;
    logic signed [QUAT_BITS-1:0] quat_y;
    logic signed [QUAT_BITS-1:0] quat_z;
    logic [2:0]                  axis_order;
  } in_t;

  typedef struct packed {
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
    logic [1:0]         status;
  } out_t;

  typedef struct packed {
    logic [1:0] ai;
    logic [1:0] aj;
    logic [1:0] ak;
    logic       odd;
  } order_t;

  // Per-item data that rides along the square root pipeline.
  typedef struct packed {
    logic [2:0]           ord;
    logic                 spec;
    logic [1:0]           code;
    logic signed [MW-1:0] n;
    logic signed [MW-1:0] s;
    logic signed [MW-1:0] ya;
    logic signed [MW-1:0] xa;
    logic signed [MW-1:0] yb;
    logic signed [MW-1:0] xb;
    logic signed [MW-1:0] yg;
    logic signed [MW-1:0] xg;
  } side_t;

  // Per-item data that rides along the CORDIC pipeline.
  typedef struct packed {
    logic [2:0] ord;
    logic       spec;
    logic [1:0] code;
    logic       gim;
  } cside_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } lane_t;

  function automatic order_t order_lookup(input logic [2:0] ord);
    order_t r;
    r = '0;
    case (ord)
      ORD_XYZ: r = '{ai: AX_X, aj: AX_Y, ak: AX_Z, odd: 1'b0};
      ORD_XZY: r = '{ai: AX_X, aj: AX_Z, ak: AX_Y, odd: 1'b1};
      ORD_YXZ: r = '{ai: AX_Y, aj: AX_X, ak: AX_Z, odd: 1'b1};
      ORD_YZX: r = '{ai: AX_Y, aj: AX_Z, ak: AX_X, odd: 1'b0};
      ORD_ZXY: r = '{ai: AX_Z, aj: AX_X, ak: AX_Y, odd: 1'b0};
      ORD_ZYX: r = '{ai: AX_Z, aj: AX_Y, ak: AX_X, odd: 1'b1};
      default: r = '0;
    endcase
    return r;
  endfunction

  // atan(2^-i) in degrees * 65536, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_tab(input int i);
    logic signed [ZW-1:0] r;
    r = '0;
    case (i)
      0:  r = ZW'(2949120);
      1:  r = ZW'(1740967);
      2:  r = ZW'(919879);
      3:  r = ZW'(466945);
      4:  r = ZW'(234379);
      5:  r = ZW'(117304);
      6:  r = ZW'(58666);
      7:  r = ZW'(29335);
      8:  r = ZW'(14668);
      9:  r = ZW'(7334);
      10: r = ZW'(3667);
      11: r = ZW'(1833);
      12: r = ZW'(917);
      13: r = ZW'(458);
      14: r = ZW'(229);
      15: r = ZW'(115);
      16: r = ZW'(57);
      17: r = ZW'(29);
      18: r = ZW'(14);
      19: r = ZW'(7);
      20: r = ZW'(4);
      21: r = ZW'(2);
      22: r = ZW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> sv/quaternion_to_euler_angles_top.sv
// Throughput: one item per cycle while out_ready does not stall; set by the single-bit-per-stage
// square root (32 stages) and the one-iteration-per-stage CORDIC, all fully pipelined.
// Reset (rst, synchronous, active high) clears every valid bit; data registers hold garbage.
// A stall on out_ready freezes the whole pipeline; the input register still takes one item if it is empty.
// Depends on qte_pkg.
module quaternion_to_euler_angles_top
  import qte_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int N  = CORDIC_STEPS;
  localparam int QW = QUAT_BITS;

  // ---------------------------------------------------------------- stage A: input
  logic a_valid;
  in_t  a_data;

  // Global advance: the pipeline moves whenever the output slot is free or drains.
  logic en;
  assign en       = !out_valid || out_ready;
  // The input register refills even during a stall if it is empty.
  assign in_ready = !a_valid || en;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      a_data <= in_data;
    end
  end

  // ---------------------------------------------------------------- stage B: magnitudes
  // The highest set bit of the OR of the magnitudes is that of the largest one.
  logic [QW-1:0]  a_abs [4];
  logic [3:0]     a_neg;
  logic [QW-1:0]  a_or;
  logic [SHW-1:0] a_msb;
  logic [SHW-1:0] a_rs;
  logic [SHW-1:0] a_ls;
  logic signed [QW-1:0] a_q [4];

  always_comb begin
    a_q[0] = a_data.quat_w;
    a_q[1] = a_data.quat_x;
    a_q[2] = a_data.quat_y;
    a_q[3] = a_data.quat_z;
    a_or   = '0;
    for (int t = 0; t < 4; t++) begin
      a_neg[t] = a_q[t][QW-1];
      a_abs[t] = a_neg[t] ? QW'(-a_q[t]) : QW'(a_q[t]);
      a_or     = a_or | a_abs[t];
    end
    a_msb = '0;
    for (int k = 0; k < QW; k++) begin
      if (a_or[k]) a_msb = SHW'(k);
    end
    a_rs = (a_msb > SHW'(14)) ? a_msb - SHW'(14) : '0;
    a_ls = (a_msb < SHW'(14)) ? SHW'(14) - a_msb : '0;
  end

  logic           b_valid;
  logic [QW-1:0]  b_abs [4];
  logic [3:0]     b_neg;
  logic [SHW-1:0] b_rs;
  logic [SHW-1:0] b_ls;
  logic [2:0]     b_ord;
  logic           b_spec;
  logic [1:0]     b_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
    if (en) begin
      b_abs  <= a_abs;
      b_neg  <= a_neg;
      b_rs   <= a_rs;
      b_ls   <= a_ls;
      b_ord  <= a_data.axis_order;
      // invalid order takes precedence over the zero quaternion
      b_spec <= (a_data.axis_order > ORD_ZYX) || (a_or == '0);
      b_code <= (a_data.axis_order > ORD_ZYX) ? ST_INVALID : ST_ZERO;
    end
  end

  // ---------------------------------------------------------------- stage C: normalize
  // Bring the largest magnitude into [2^14, 2^15); halving truncates toward zero.
  logic [QW+14:0]     b_mag [4];
  logic signed [15:0] b_nq  [4];

  always_comb begin
    for (int t = 0; t < 4; t++) begin
      b_mag[t] = (QW'(0) + {15'b0, b_abs[t]}) >> b_rs;
      b_mag[t] = b_mag[t] << b_ls;
      b_nq[t]  = b_neg[t] ? -$signed({1'b0, b_mag[t][14:0]}) : $signed({1'b0, b_mag[t][14:0]});
    end
  end

  logic               c_valid;
  logic signed [15:0] c_q [4];
  logic [2:0]         c_ord;
  logic               c_spec;
  logic [1:0]         c_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid;
    end
    if (en) begin
      c_q    <= b_nq;
      c_ord  <= b_ord;
      c_spec <= b_spec;
      c_code <= b_code;
    end
  end

  // ---------------------------------------------------------------- stage D: products
  logic               d_valid;
  logic signed [31:0] d_ww, d_xx, d_yy, d_zz, d_xy, d_wz, d_xz, d_wy, d_yz, d_wx;
  logic [2:0]         d_ord;
  logic               d_spec;
  logic [1:0]         d_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= c_valid;
    end
    if (en) begin
      d_ww   <= c_q[0] * c_q[0];
      d_xx   <= c_q[1] * c_q[1];
      d_yy   <= c_q[2] * c_q[2];
      d_zz   <= c_q[3] * c_q[3];
      d_xy   <= c_q[1] * c_q[2];
      d_wz   <= c_q[0] * c_q[3];
      d_xz   <= c_q[1] * c_q[3];
      d_wy   <= c_q[0] * c_q[2];
      d_yz   <= c_q[2] * c_q[3];
      d_wx   <= c_q[0] * c_q[1];
      d_ord  <= c_ord;
      d_spec <= c_spec;
      d_code <= c_code;
    end
  end

  // ---------------------------------------------------------------- stage E: matrix
  // m[col][row], every entry scaled by the squared norm n.
  logic signed [MW-1:0] d_n;
  logic signed [MW-1:0] d_m [3][3];

  always_comb begin
    d_n = MW'(d_ww) + MW'(d_xx) + MW'(d_yy) + MW'(d_zz);
    d_m[0][0] = d_n - ((MW'(d_yy) + MW'(d_zz)) <<< 1);
    d_m[0][1] = (MW'(d_xy) + MW'(d_wz)) <<< 1;
    d_m[0][2] = (MW'(d_xz) - MW'(d_wy)) <<< 1;
    d_m[1][0] = (MW'(d_xy) - MW'(d_wz)) <<< 1;
    d_m[1][1] = d_n - ((MW'(d_xx) + MW'(d_zz)) <<< 1);
    d_m[1][2] = (MW'(d_yz) + MW'(d_wx)) <<< 1;
    d_m[2][0] = (MW'(d_xz) + MW'(d_wy)) <<< 1;
    d_m[2][1] = (MW'(d_yz) - MW'(d_wx)) <<< 1;
    d_m[2][2] = d_n - ((MW'(d_xx) + MW'(d_yy)) <<< 1);
  end

  logic                 e_valid;
  logic signed [MW-1:0] e_n;
  logic signed [MW-1:0] e_m [3][3];
  logic [2:0]           e_ord;
  logic                 e_spec;
  logic [1:0]           e_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (en) begin
      e_valid <= d_valid;
    end
    if (en) begin
      e_n    <= d_n;
      e_m    <= d_m;
      e_ord  <= d_ord;
      e_spec <= d_spec;
      e_code <= d_code;
    end
  end

  // ---------------------------------------------------------------- stage F: pick entries
  order_t               e_o;
  logic signed [MW-1:0] e_mik;
  logic signed [MW-1:0] e_s;
  side_t                e_side;

  always_comb begin
    e_o   = order_lookup(e_ord);
    e_mik = e_m[e_o.ai][e_o.ak];
    e_s   = e_o.odd ? e_mik : -e_mik;
    if (e_s > e_n) e_s = e_n;
    if (e_s < -e_n) e_s = -e_n;
    e_side.ord  = e_ord;
    e_side.spec = e_spec;
    e_side.code = e_code;
    e_side.n    = e_n;
    e_side.s    = e_s;
    e_side.ya   = e_o.odd ? -e_m[e_o.aj][e_o.ak] : e_m[e_o.aj][e_o.ak];
    e_side.xa   = e_m[e_o.ak][e_o.ak];
    e_side.yb   = e_o.odd ? -e_m[e_o.ai][e_o.aj] : e_m[e_o.ai][e_o.aj];
    e_side.xb   = e_m[e_o.ai][e_o.ai];
    e_side.yg   = e_o.odd ? e_m[e_o.aj][e_o.ai] : -e_m[e_o.aj][e_o.ai];
    e_side.xg   = e_m[e_o.aj][e_o.aj];
  end

  logic  f_valid;
  side_t f_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (en) begin
      f_valid <= e_valid;
    end
    if (en) begin
      f_side <= e_side;
    end
  end

  // ---------------------------------------------------------------- stage G: n^2, s^2
  logic [RB-1:0] f_sabs;
  assign f_sabs = f_side.s[MW-1] ? RB'(-f_side.s) : RB'(f_side.s);

  logic          g_valid;
  logic [63:0]   g_nn;
  logic [63:0]   g_ss;
  side_t         g_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else if (en) begin
      g_valid <= f_valid;
    end
    if (en) begin
      g_nn   <= 64'(f_side.n[RB-1:0]) * 64'(f_side.n[RB-1:0]);
      g_ss   <= 64'(f_sabs) * 64'(f_sabs);
      g_side <= f_side;
    end
  end

  // ---------------------------------------------------------------- square root
  // Entry 0 holds the radicand; each following stage settles one root bit, MSB first.
  logic          sq_valid [0:RB];
  logic [63:0]   sq_rem   [0:RB];
  logic [RB-1:0] sq_root  [0:RB];
  side_t         sq_side  [0:RB];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid[0] <= 1'b0;
    end else if (en) begin
      sq_valid[0] <= g_valid;
    end
    if (en) begin
      sq_rem[0]  <= g_nn - g_ss;
      sq_root[0] <= '0;
      sq_side[0] <= g_side;
    end
  end

  for (genvar t = 0; t < RB; t++) begin : g_sqrt
    localparam int B = RB - 1 - t;
    logic [63:0] trial;
    assign trial = (64'(sq_root[t]) << (B + 1)) | (64'd1 << (2 * B));

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_valid[t+1] <= 1'b0;
      end else if (en) begin
        sq_valid[t+1] <= sq_valid[t];
      end
      if (en) begin
        if (sq_rem[t] >= trial) begin
          sq_rem[t+1]  <= sq_rem[t] - trial;
          sq_root[t+1] <= sq_root[t] | (RB'(1) << B);
        end else begin
          sq_rem[t+1]  <= sq_rem[t];
          sq_root[t+1] <= sq_root[t];
        end
        sq_side[t+1] <= sq_side[t];
      end
    end
  end

  // ---------------------------------------------------------------- gimbal test
  // Lock when cos * 10^7 <= n; multiply in one stage, compare in the next.
  logic          p_valid;
  logic [55:0]   p_prod;
  logic [RB-1:0] p_c;
  side_t         p_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (en) begin
      p_valid <= sq_valid[RB];
    end
    if (en) begin
      p_prod <= 56'(sq_root[RB]) * 56'(GIMBAL_DEN);
      p_c    <= sq_root[RB];
      p_side <= sq_side[RB];
    end
  end

  logic          q_valid;
  logic          q_gim;
  logic [RB-1:0] q_c;
  side_t         q_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (en) begin
      q_valid <= p_valid;
    end
    if (en) begin
      q_gim  <= p_prod <= 56'(p_side.n[RB-1:0]);
      q_c    <= p_c;
      q_side <= p_side;
    end
  end

  // ---------------------------------------------------------------- CORDIC
  // Three lanes: 0 middle angle, 1 first angle, 2 last angle (or remainder under lock).
  function automatic lane_t prerot(input logic signed [CW-1:0] y, input logic signed [CW-1:0] x);
    lane_t r;
    r.zero = (x == '0) && (y == '0);
    r.x    = x;
    r.y    = y;
    r.z    = '0;
    if (x < 0) begin
      if (y >= 0) begin
        r.x = y;
        r.y = -x;
        r.z = Z90;
      end else begin
        r.x = -y;
        r.y = x;
        r.z = -Z90;
      end
    end
    return r;
  endfunction

  logic   cv    [0:N];
  lane_t  cl    [0:N][3];
  cside_t cs    [0:N];

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (en) begin
      cv[0] <= q_valid;
    end
    if (en) begin
      cl[0][0] <= prerot(CW'(q_side.s), CW'($signed({1'b0, q_c})));
      cl[0][1] <= prerot(CW'(q_side.ya), CW'(q_side.xa));
      cl[0][2] <= q_gim ? prerot(CW'(q_side.yg), CW'(q_side.xg))
                        : prerot(CW'(q_side.yb), CW'(q_side.xb));
      cs[0]    <= '{ord: q_side.ord, spec: q_side.spec, code: q_side.code, gim: q_gim};
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else if (en) begin
        cv[i+1] <= cv[i];
      end
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          cl[i+1][l].zero <= cl[i][l].zero;
          if (!cl[i][l].y[CW-1]) begin
            cl[i+1][l].x <= cl[i][l].x + (cl[i][l].y >>> i);
            cl[i+1][l].y <= cl[i][l].y - (cl[i][l].x >>> i);
            cl[i+1][l].z <= cl[i][l].z + atan_tab(i);
          end else begin
            cl[i+1][l].x <= cl[i][l].x - (cl[i][l].y >>> i);
            cl[i+1][l].y <= cl[i][l].y + (cl[i][l].x >>> i);
            cl[i+1][l].z <= cl[i][l].z - atan_tab(i);
          end
        end
        cs[i+1] <= cs[i];
      end
    end
  end

  // ---------------------------------------------------------------- output
  function automatic logic signed [15:0] to_out(input logic signed [ZW-1:0] z);
    logic signed [ZW:0] sum;
    logic signed [ZW:0] r;
    sum = (ZW+1)'(z) + (ZW+1)'(256);
    r   = sum >>> 9;
    if (r > (ZW+1)'(OUT_LIMIT)) r = (ZW+1)'(OUT_LIMIT);
    if (r < -(ZW+1)'(OUT_LIMIT)) r = -(ZW+1)'(OUT_LIMIT);
    return r[15:0];
  endfunction

  order_t             o_o;
  logic signed [15:0] o_lane [3];
  logic signed [15:0] o_ang  [3];
  out_t               o_data;

  always_comb begin
    o_o = order_lookup(cs[N].ord);
    for (int l = 0; l < 3; l++) begin
      o_lane[l] = cl[N][l].zero ? 16'sd0 : to_out(cl[N][l].z);
    end
    o_ang[0] = '0;
    o_ang[1] = '0;
    o_ang[2] = '0;
    if (!cs[N].spec) begin
      o_ang[o_o.aj] = o_lane[0];
      o_ang[o_o.ai] = cs[N].gim ? 16'sd0 : o_lane[1];
      o_ang[o_o.ak] = o_lane[2];
    end
    o_data.angle_x = o_ang[0];
    o_data.angle_y = o_ang[1];
    o_data.angle_z = o_ang[2];
    if (cs[N].spec) begin
      o_data.status = cs[N].code;
    end else begin
      o_data.status = cs[N].gim ? ST_GIMBAL : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= cv[N];
    end
    if (en) begin
      out_data <= o_data;
    end
  end

endmodule

>>> sv/qte_checker.sv
// Port-level checker for the quaternion to Euler angles block, bound to its top level.
// Depends on qte_pkg and quaternion_to_euler_angles_top_defines.svh.
`include "quaternion_to_euler_angles_top_defines.svh"

module qte_checker
  import qte_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input in_t  in_data,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  logic special_code;
  logic angles_zero;
  logic angles_in_range;

  assign special_code = (out_data.status == ST_INVALID) || (out_data.status == ST_ZERO);
  assign angles_zero  = (out_data.angle_x == 16'sd0) && (out_data.angle_y == 16'sd0) &&
                        (out_data.angle_z == 16'sd0);
  assign angles_in_range =
    (out_data.angle_x <= 16'sd23040) && (out_data.angle_x >= -16'sd23040) &&
    (out_data.angle_y <= 16'sd23040) && (out_data.angle_y >= -16'sd23040) &&
    (out_data.angle_z <= 16'sd23040) && (out_data.angle_z >= -16'sd23040);

  // an empty output slot never blocks the input side
  `QTE_ASSERT_NOW(a_ready_when_drained, !out_valid, in_ready, "input blocked with empty output")

  // held result stays put while stalled
  `QTE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed under stall")

  // offered input stays put until its transfer
  `QTE_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_data), "input changed while waiting")

  `QTE_ASSERT_NOW(a_special_zero, out_valid && special_code, angles_zero, "special case with nonzero angle")

  `QTE_ASSERT_NOW(a_angle_range, out_valid, angles_in_range, "angle out of range")

endmodule

bind quaternion_to_euler_angles_top qte_checker u_qte_checker (.*);

>>> dv/quaternion_to_euler_angles_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the quaternion to Euler angles block: predicts the angles
// of each input transfer and checks them against the output transfers. Depends on qte_pkg.
module quaternion_to_euler_angles_checker
  import qte_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_ready,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  out_t out_data,
  output int   errors,
  output int   outstanding,
  output int   n_gimbal,
  output int   n_checked
);

  localparam longint ATAN_DEG [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

  out_t expected_angles[$];

  function automatic longint unsigned isqrt64(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Vectoring-mode arctangent, degrees * 65536; shifts round toward minus infinity
  function automatic longint vector_angle(input longint y, input longint x);
    longint a, nx, ny, t;
    a = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; a = 90 * DEG_ONE;
      end else begin
        x = -y; y = t; a = -90 * DEG_ONE;
      end
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); a += ATAN_DEG[i];
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); a -= ATAN_DEG[i];
      end
      x = nx;
      y = ny;
    end
    return a;
  endfunction

  function automatic logic signed [15:0] to_deg128(input longint a);
    longint r;
    r = (a + 256) >>> 9;
    if (r > OUT_LIMIT) r = OUT_LIMIT;
    if (r < -OUT_LIMIT) r = -OUT_LIMIT;
    return r[15:0];
  endfunction

  function automatic out_t euler_from_quat(input in_t q_in);
    out_t r;
    longint q[4], m[3][3], ang[3];
    longint mx, n, s, w, x, y, z;
    longint unsigned c;
    int ai, aj, ak;
    bit odd, gim;
    r = '0;
    ang = '{0, 0, 0};
    case (q_in.axis_order)
      ORD_XYZ: begin ai = 0; aj = 1; ak = 2; odd = 0; end
      ORD_XZY: begin ai = 0; aj = 2; ak = 1; odd = 1; end
      ORD_YXZ: begin ai = 1; aj = 0; ak = 2; odd = 1; end
      ORD_YZX: begin ai = 1; aj = 2; ak = 0; odd = 0; end
      ORD_ZXY: begin ai = 2; aj = 0; ak = 1; odd = 0; end
      ORD_ZYX: begin ai = 2; aj = 1; ak = 0; odd = 1; end
      default: begin
        r.status = ST_INVALID;
        return r;
      end
    endcase
    q[0] = q_in.quat_w; q[1] = q_in.quat_x; q[2] = q_in.quat_y; q[3] = q_in.quat_z;
    mx = 0;
    foreach (q[t]) if ((q[t] < 0 ? -q[t] : q[t]) > mx) mx = q[t] < 0 ? -q[t] : q[t];
    if (mx == 0) begin
      r.status = ST_ZERO;
      return r;
    end
    // normalize magnitude into [2^14, 2^15)
    while (mx >= (64'sd1 << 15)) begin
      foreach (q[t]) q[t] = q[t] >= 0 ? q[t] >>> 1 : -((-q[t]) >>> 1);
      mx >>= 1;
    end
    while (mx < (64'sd1 << 14)) begin
      foreach (q[t]) q[t] *= 2;
      mx *= 2;
    end
    w = q[0]; x = q[1]; y = q[2]; z = q[3];
    n = w*w + x*x + y*y + z*z;
    m[0][0] = n - 2*(y*y + z*z);
    m[0][1] = 2*(x*y + w*z);
    m[0][2] = 2*(x*z - w*y);
    m[1][0] = 2*(x*y - w*z);
    m[1][1] = n - 2*(x*x + z*z);
    m[1][2] = 2*(y*z + w*x);
    m[2][0] = 2*(x*z + w*y);
    m[2][1] = 2*(y*z - w*x);
    m[2][2] = n - 2*(x*x + y*y);
    s = odd ? m[ai][ak] : -m[ai][ak];
    if (s > n) s = n;
    if (s < -n) s = -n;
    c = isqrt64(longint'(unsigned'(n)) * longint'(unsigned'(n))
                - longint'(unsigned'(s < 0 ? -s : s)) * longint'(unsigned'(s < 0 ? -s : s)));
    gim = c * 64'd10000000 <= longint'(unsigned'(n));
    ang[aj] = vector_angle(s, longint'(c));
    if (!gim) begin
      ang[ai] = vector_angle(odd ? -m[aj][ak] : m[aj][ak], m[ak][ak]);
      ang[ak] = vector_angle(odd ? -m[ai][aj] : m[ai][aj], m[ai][ai]);
      r.status = ST_OK;
    end else begin
      ang[ak] = vector_angle(odd ? m[aj][ai] : -m[aj][ai], m[aj][aj]);
      r.status = ST_GIMBAL;
    end
    r.angle_x = to_deg128(ang[0]);
    r.angle_y = to_deg128(ang[1]);
    r.angle_z = to_deg128(ang[2]);
    return r;
  endfunction

  assign outstanding = expected_angles.size();

  initial begin
    errors = 0;
    n_gimbal = 0;
    n_checked = 0;
  end

  always @(posedge clk) begin
    out_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        want = euler_from_quat(in_data);
        if (want.status == ST_GIMBAL) n_gimbal++;
        expected_angles.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (expected_angles.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %p", $time, out_data);
        end else begin
          want = expected_angles.pop_front();
          n_checked++;
          if (out_data.angle_x !== want.angle_x || out_data.angle_y !== want.angle_y ||
              out_data.angle_z !== want.angle_z || out_data.status !== want.status) begin
            errors++;
            $display("%0t: mismatch expected %p actual %p", $time, want, out_data);
          end
        end
      end
    end
  end

endmodule

>>> dv/quaternion_to_euler_angles_top_test.sv
`timescale 1ns / 100ps
// Top of the quaternion to Euler angles testbench: clock, reset, stimulus, verdict.
// Depends on qte_pkg, the block and quaternion_to_euler_angles_checker.
module quaternion_to_euler_angles_top_test;
  import qte_pkg::*;

  localparam int N_RANDOM   = 1130;
  localparam int STALL_LONG = 300;   // receiver hold-off, longer than the pipeline
  localparam int IDLE_LIMIT = 5000;  // cycles with no transfer before giving up
  localparam int DRAIN      = 80;    // extra wait after the scoreboard empties

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  in_t  in_data;
  out_t out_data;
  int   errors, outstanding, n_gimbal, n_checked;
  int   n_sent;
  int   idle_cycles;

  quaternion_to_euler_angles_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  quaternion_to_euler_angles_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .errors(errors), .outstanding(outstanding),
    .n_gimbal(n_gimbal), .n_checked(n_checked)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one item, hold it until the transfer, then maybe idle.
  task automatic send(input in_t item);
    int gap;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic in_t mk(input int w, input int x, input int y, input int z,
                             input logic [2:0] ord);
    in_t q;
    q.quat_w = w[15:0]; q.quat_x = x[15:0]; q.quat_y = y[15:0]; q.quat_z = z[15:0];
    q.axis_order = ord;
    return q;
  endfunction

  // Random item: full range, tiny magnitudes, near gimbal lock, or w and x zero.
  function automatic in_t random_quat();
    in_t q;
    int kind, a, nz;
    logic [2:0] ord;
    kind = $urandom_range(0, 9);
    ord  = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
    q = {$urandom, $urandom, 3'd0};
    q.axis_order = ord;
    if (kind < 2) begin
      // small components exercise the doubling normalization
      q.quat_w = 16'($signed($urandom_range(0, 63)) - 32);
      q.quat_x = 16'($signed($urandom_range(0, 63)) - 32);
      q.quat_y = 16'($signed($urandom_range(0, 63)) - 32);
      q.quat_z = 16'($signed($urandom_range(0, 63)) - 32);
    end else if (kind < 4) begin
      // a pair of equal magnitudes puts the middle angle near +/-90
      a  = $urandom_range(1, 32767);
      nz = $urandom_range(0, 3);
      q = mk(a, $urandom_range(0, 1) ? a : -a, nz, -nz, ord);
      case ($urandom_range(0, 2))
        0: q = mk(a, nz, $urandom_range(0, 1) ? a : -a, nz, ord);
        1: q = mk(a, nz, -nz, $urandom_range(0, 1) ? a : -a, ord);
        default: ;
      endcase
    end else if (kind == 4) begin
      q.quat_w = 16'sh0; q.quat_x = 16'sh0;
    end
    return q;
  endfunction

  // Receiver: random back-pressure plus one long hold-off while items keep coming.
  initial begin
    bit held;
    int gap;
    held = 0;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!held && n_sent >= 300) begin
        held = 1;
        out_ready <= 1'b0;
        repeat (STALL_LONG) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        gap = pick_gap();
        if (gap == 0 || n_sent > 700 && n_sent < 800) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          repeat (gap - 1) @(posedge clk);
        end
      end
    end
  end

  // Watchdog: count cycles with no transfer on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    logic [2:0] ord;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    n_sent = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: invalid orders, zero quaternion, extremes, identity, gimbal lock.
    send(mk(0, 0, 0, 0, 3'd6));
    send(mk(16384, 0, 0, 0, 3'd7));
    send(mk(0, 0, 0, 0, ORD_XYZ));
    send(mk(1, 0, 0, 0, ORD_ZYX));
    send(mk(-32768, -32768, -32768, -32768, ORD_XYZ));
    send(mk(32767, 32767, 32767, 32767, ORD_YZX));
    send(mk(-32768, 32767, 0, -1, ORD_ZXY));
    send(mk(0, -32768, 0, 0, ORD_XZY));
    for (int i = 0; i < 6; i++) begin
      ord = 3'(i);
      send(mk(16384, 16384, 0, 0, ord));
      send(mk(16384, 0, -16384, 0, ord));
      send(mk(-16384, 0, 0, 16384, ord));
    end

    for (int i = 0; i < N_RANDOM; i++) send(random_quat());
    in_valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("sent %0d quaternions over all six axis orders and both invalid codes;",
             n_sent);
    $display("checked %0d results, %0d of them in gimbal lock", n_checked, n_gimbal);
    if (errors == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
